/* sv/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// shared widths, types, cofactor index tables and pipeline depths for the
// 3x3 matrix inverse
// ----------------------------------------------------------------------------
package mi3_pkg;

    // element format
    localparam int ELEMENT_BITS  = 16;
    localparam int FRACTION_BITS = 12;
    localparam int N_ENT         = 9;

    // result format
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_BITS      = 32;

    // threshold register
    localparam int              THR_W     = 47;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(68719);

    // derived arithmetic widths
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int COF_W  = 2 * ELEMENT_BITS + 1;
    localparam int DP_W   = 3 * ELEMENT_BITS + 1;
    localparam int DET_W  = 3 * ELEMENT_BITS + 3;
    localparam int SHIFT  = FRACTION_BITS + OUT_FRAC_BITS;
    localparam int NUM_W  = COF_W + SHIFT + 1;
    localparam int HI_W   = NUM_W - OUT_BITS;
    localparam int REM_W  = DET_W + 1;
    localparam int PRE_W  = (HI_W > DET_W) ? HI_W : DET_W;
    localparam int TC_W   = (DET_W > THR_W) ? DET_W : THR_W;

    // pipeline depth: front end, divider (set-up plus one stage per bit), output
    localparam int FRONT_ST = 5;
    localparam int DIV_ST   = OUT_BITS + 1;
    localparam int N_ST     = FRONT_ST + DIV_ST + 1;

    // stream widths
    localparam int IN_TDATA_W  = ((N_ENT * ELEMENT_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((N_ENT * OUT_BITS + 7) / 8) * 8;

    // saturation limits
    localparam logic [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef logic signed [ELEMENT_BITS-1:0] elem_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [COF_W-1:0]        cof_t;
    typedef logic signed [DP_W-1:0]         dp_t;
    typedef logic signed [DET_W-1:0]        det_t;

    // cofactor i = a[CP_A]*a[CP_B] - a[CM_A]*a[CM_B], row-major adjugate
    localparam int CP_A [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CP_B [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CM_A [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CM_B [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // front end to divider bank
    typedef struct packed {
        logic                          sing;
        logic [DET_W-1:0]              den;
        logic [N_ENT-1:0]              neg;
        logic [N_ENT-1:0][NUM_W-1:0]   num;
    } front_out_t;

endpackage

/* sv/mi3_front.sv */
// ----------------------------------------------------------------------------
// mi3_front
// five-stage front end: products, cofactors, determinant terms, determinant,
// then magnitudes, rounding bias and singular test
// ----------------------------------------------------------------------------
module mi3_front (
    input  logic                                             clk,
    input  logic [mi3_pkg::FRONT_ST-1:0]                     en,
    input  logic [mi3_pkg::N_ENT-1:0][mi3_pkg::ELEMENT_BITS-1:0] a,
    input  logic [mi3_pkg::THR_W-1:0]                        thr,
    output mi3_pkg::front_out_t                              res
);
    import mi3_pkg::*;

    elem_t      a_s [N_ENT];
    prod_t      pp_reg [N_ENT];
    prod_t      pm_reg [N_ENT];
    elem_t      at0_reg [3];
    cof_t       cof1_reg [N_ENT];
    elem_t      at1_reg [3];
    dp_t        dp2_reg [3];
    cof_t       cof2_reg [N_ENT];
    det_t       det3_reg;
    cof_t       cof3_reg [N_ENT];
    logic [DET_W-1:0] det_mag;
    front_out_t res_next;
    front_out_t res_reg;

    always_comb
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            a_s[i] = elem_t'(a[i]);
        end
    end

    // stage 0: the eighteen products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                pp_reg[i] <= prod_t'(a_s[CP_A[i]]) * prod_t'(a_s[CP_B[i]]);
                pm_reg[i] <= prod_t'(a_s[CM_A[i]]) * prod_t'(a_s[CM_B[i]]);
            end
            for (int i = 0; i < 3; i++)
            begin
                at0_reg[i] <= a_s[i];
            end
        end
    end

    // stage 1: cofactors
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                cof1_reg[i] <= cof_t'(pp_reg[i]) - cof_t'(pm_reg[i]);
            end
            at1_reg <= at0_reg;
        end
    end

    // stage 2: determinant terms along the top row
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dp2_reg[0] <= dp_t'(at1_reg[0]) * dp_t'(cof1_reg[0]);
            dp2_reg[1] <= dp_t'(at1_reg[1]) * dp_t'(cof1_reg[3]);
            dp2_reg[2] <= dp_t'(at1_reg[2]) * dp_t'(cof1_reg[6]);
            cof2_reg   <= cof1_reg;
        end
    end

    // stage 3: determinant
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            det3_reg <= det_t'(dp2_reg[0]) + det_t'(dp2_reg[1]) + det_t'(dp2_reg[2]);
            cof3_reg <= cof2_reg;
        end
    end

    // stage 4: magnitudes, biased numerators, singular test
    always_comb
    begin
        det_mag = det3_reg[DET_W-1] ? DET_W'(-det3_reg) : DET_W'(det3_reg);
        res_next.den  = det_mag;
        res_next.sing = (det_mag == '0) || (TC_W'(det_mag) < TC_W'(thr));
        for (int i = 0; i < N_ENT; i++)
        begin
            res_next.neg[i] = cof3_reg[i][COF_W-1] ^ det3_reg[DET_W-1];
            res_next.num[i] = (NUM_W'(cof3_reg[i][COF_W-1] ? COF_W'(-cof3_reg[i])
                                                           : COF_W'(cof3_reg[i])) << SHIFT)
                            + NUM_W'(det_mag >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* sv/mi3_div.sv */
// ----------------------------------------------------------------------------
// mi3_div
// pipelined restoring divider, one quotient bit per stage, with an
// overflow test in the set-up stage
// ----------------------------------------------------------------------------
module mi3_div (
    input  logic                            clk,
    input  logic [mi3_pkg::DIV_ST-1:0]      en,
    input  logic [mi3_pkg::NUM_W-1:0]       num,
    input  logic [mi3_pkg::DET_W-1:0]       den,
    input  logic                            neg,
    output logic [mi3_pkg::OUT_BITS-1:0]    quo,
    output logic                            ovf,
    output logic                            neg_o
);
    import mi3_pkg::*;

    logic [REM_W-1:0]    rem_reg [DIV_ST];
    logic [OUT_BITS-1:0] lo_reg  [DIV_ST];
    logic [OUT_BITS-1:0] q_reg   [DIV_ST];
    logic [DET_W-1:0]    d_reg   [DIV_ST];
    logic                ovf_reg [DIV_ST];
    logic                neg_reg [DIV_ST];
    logic [REM_W-1:0]    trial   [DIV_ST];
    logic                ge      [DIV_ST];

    always_comb
    begin
        trial[0] = '0;
        ge[0]    = 1'b0;
        for (int k = 1; k < DIV_ST; k++)
        begin
            trial[k] = {rem_reg[k-1][REM_W-2:0], lo_reg[k-1][OUT_BITS-1]};
            ge[k]    = trial[k] >= REM_W'(d_reg[k-1]);
        end
    end

    // set-up: quotient needs more than OUT_BITS bits when the top part reaches den
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ovf_reg[0] <= PRE_W'(num[NUM_W-1:OUT_BITS]) >= PRE_W'(den);
            rem_reg[0] <= REM_W'(num[NUM_W-1:OUT_BITS]);
            lo_reg[0]  <= num[OUT_BITS-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= neg;
        end
        for (int k = 1; k < DIV_ST; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= ge[k] ? trial[k] - REM_W'(d_reg[k-1]) : trial[k];
                lo_reg[k]  <= {lo_reg[k-1][OUT_BITS-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][OUT_BITS-2:0], ge[k]};
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo   = q_reg[DIV_ST-1];
    assign ovf   = ovf_reg[DIV_ST-1];
    assign neg_o = neg_reg[DIV_ST-1];

endmodule

/* sv/matrix_3x3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix_3x3_inverse
// inverse of one signed q4.12 3x3 matrix per beat by adjugate over
// determinant, rounded and saturated to q16.16, with a singular flag
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------------
//   s_      | in        | s_tvalid/tready  | s_tdata: nine q4.12 entries
//   m_      | out       | m_tvalid/tready  | m_tdata: nine q16.16, m_tuser: singular
//   cfg_    | in        | cfg_we           | cfg_wdata: det_threshold
//
// one beat enters per cycle unless the pipeline is full and the output stalls;
// 5 front-end stages, 33-stage divider (one quotient bit each), output register
// every stage carries a valid bit; a stage takes a new beat when it is empty
// or its successor moves, so bubbles close up while the output is stalled
// reset clears the valid bits and loads det_threshold with 68719 (about 1e-6)
// the user must write det_threshold only while the pipeline holds no beats;
// the block itself does not enforce this
module matrix_3x3_inverse (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ... in_r2c2, 16 bits each
    input  logic [mi3_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, ... inv_r2c2, 32 bits each
    output logic [mi3_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // singular
    output logic                                m_tuser,
    input  logic                                cfg_we,
    input  logic [mi3_pkg::THR_W-1:0]           cfg_wdata
);
    import mi3_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic [N_ST-1:0]  v_reg;
    logic [N_ST-1:0]  v_next;
    logic [N_ST-1:0]  en;

    logic [N_ENT-1:0][ELEMENT_BITS-1:0] a;
    front_out_t                         fres;

    logic [OUT_BITS-1:0] quo   [N_ENT];
    logic                ovf   [N_ENT];
    logic                neg_o [N_ENT];
    logic                sing_reg [DIV_ST];

    logic [N_ENT-1:0][OUT_BITS-1:0] ent_next;
    logic [N_ENT-1:0][OUT_BITS-1:0] ent_reg;
    logic                           sing_out_reg;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[N_ST-1] = !v_reg[N_ST-1] || m_tready;
        for (int k = N_ST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < N_ST; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[N_ST-1];

    // unpack entries, lowest bits first
    always_comb
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            a[i] = s_tdata[i*ELEMENT_BITS +: ELEMENT_BITS];
        end
    end

    mi3_front u_front (
        .clk (clk),
        .en  (en[FRONT_ST-1:0]),
        .a   (a),
        .thr (thr_reg),
        .res (fres)
    );

    for (genvar i = 0; i < N_ENT; i++)
    begin : g_div
        mi3_div u_div (
            .clk   (clk),
            .en    (en[FRONT_ST +: DIV_ST]),
            .num   (fres.num[i]),
            .den   (fres.den),
            .neg   (fres.neg[i]),
            .quo   (quo[i]),
            .ovf   (ovf[i]),
            .neg_o (neg_o[i])
        );
    end

    // singular flag rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en[FRONT_ST])
        begin
            sing_reg[0] <= fres.sing;
        end
        for (int k = 1; k < DIV_ST; k++)
        begin
            if (en[FRONT_ST+k])
            begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // saturate, apply sign, zero out singular results
    always_comb
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            if (sing_reg[DIV_ST-1])
            begin
                ent_next[i] = '0;
            end
            else if (neg_o[i])
            begin
                ent_next[i] = (ovf[i] || (quo[i] > SAT_NEG)) ? SAT_NEG : OUT_BITS'(-quo[i]);
            end
            else
            begin
                ent_next[i] = (ovf[i] || (quo[i] > SAT_POS)) ? SAT_POS : quo[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[N_ST-1])
        begin
            ent_reg      <= ent_next;
            sing_out_reg <= sing_reg[DIV_ST-1];
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < N_ENT; i++)
        begin
            m_tdata[i*OUT_BITS +: OUT_BITS] = ent_reg[i];
        end
    end

    assign m_tuser = sing_out_reg;

    // a singular beat carries an all-zero matrix
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular beat with nonzero entries");

    // any empty stage means the input side can move
    a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!(&v_reg)) |-> s_tready)
        else $error("input stalled with a free stage");

    // an accepted beat occupies the first stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted beat lost at entry");

    // a full pipeline with a stalled output takes nothing in
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !m_tready) |-> !s_tready)
        else $error("beat taken while pipeline full");

endmodule
